// ===== design/rmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmc_pkg;

   localparam int MAX_RECTS   = 16;
   localparam int IDX_W       = $clog2(MAX_RECTS);
   localparam int COUNT_W     = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic signed [15:0] coord_type;
   typedef logic [14:0]        size_type;
   typedef logic signed [16:0] delta_type;
   typedef logic signed [17:0] wide_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_MOVE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      DIR_UP    = 3'd0,
      DIR_DOWN  = 3'd1,
      DIR_LEFT  = 3'd2,
      DIR_RIGHT = 3'd3,
      DIR_NONE  = 3'd4
   } dir_type;

   typedef enum logic [2:0] {
      STATUS_MOVED     = 3'd0,
      STATUS_BLOCKED   = 3'd1,
      STATUS_RANGE     = 3'd2,
      STATUS_LOADED    = 3'd3,
      STATUS_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_MOVE,
      KIND_BAD
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CAND,
      ST_SCAN,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      size_type  w;
      size_type  h;
   } rect_type;

   localparam rect_type RECT_RESET = '{x: 16'sd0, y: 16'sd0, w: 15'd1, h: 15'd1};

   // Work item handed from the front to the back through the queue.
   typedef struct packed {
      kind_type  kind;
      idx_type   index;
      rect_type  rect;
      delta_type delta_x;
      delta_type delta_y;
   } item_type;

   function automatic count_type used_count(input count_type rect_count);
      count_type result;
      if (rect_count > count_type'(MAX_RECTS)) begin
         result = count_type'(MAX_RECTS);
      end else begin
         result = rect_count;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/rmc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmc_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [3:0]        req_index,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [14:0]       req_width,
   input  wire logic [14:0]       req_height,
   input  wire logic [2:0]        req_direction,
   input  wire logic signed [15:0] req_distance,
   input  wire rmc_pkg::count_type rect_count,
   input  wire logic              queue_full,
   output logic                   push,
   output rmc_pkg::item_type      push_item
);

   rmc_pkg::count_type used;
   rmc_pkg::delta_type move_dist;

   assign used      = rmc_pkg::used_count(rect_count);
   assign move_dist = rmc_pkg::delta_type'(req_distance);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the item and turn the direction into a signed offset per axis.
   always_comb begin
      push_item.index   = rmc_pkg::idx_type'(req_index);
      push_item.rect.x  = req_pos_x;
      push_item.rect.y  = req_pos_y;
      push_item.rect.w  = req_width;
      push_item.rect.h  = req_height;
      push_item.delta_x = '0;
      push_item.delta_y = '0;
      if (rmc_pkg::count_type'(req_index) >= used) begin
         push_item.kind = rmc_pkg::KIND_BAD;
      end else if (rmc_pkg::op_type'(req_op) == rmc_pkg::OP_LOAD) begin
         push_item.kind = rmc_pkg::KIND_LOAD;
      end else begin
         push_item.kind = rmc_pkg::KIND_MOVE;
      end
      case (rmc_pkg::dir_type'(req_direction))
         rmc_pkg::DIR_UP:    push_item.delta_y = move_dist;
         rmc_pkg::DIR_DOWN:  push_item.delta_y = -move_dist;
         rmc_pkg::DIR_LEFT:  push_item.delta_x = -move_dist;
         rmc_pkg::DIR_RIGHT: push_item.delta_x = move_dist;
         default: begin
            push_item.delta_x = '0;
            push_item.delta_y = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/rmc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rmc_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output rmc_pkg::item_type      pop_item
);

   localparam int PTR_W = $clog2(rmc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rmc_pkg::QUEUE_DEPTH + 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   rmc_pkg::item_type slot_ff [rmc_pkg::QUEUE_DEPTH];
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   cnt_type count_ff, count_in;
   logic    do_pop;

   assign full      = (count_ff == cnt_type'(rmc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? ptr_type'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_type'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = cnt_type'(count_ff + 1'b1);
      end else if (!push && do_pop) begin
         count_in = cnt_type'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/rmc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rmc_pkg::count_type rect_count,
   input  wire logic              q_valid,
   input  wire rmc_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [3:0]             rsp_entry_index,
   output logic signed [15:0]     rsp_new_x,
   output logic signed [15:0]     rsp_new_y
);

   rmc_pkg::back_state_type state_ff, state_in;

   // Rectangle table: one write and one registered read per cycle.
   rmc_pkg::rect_type mem_ff [rmc_pkg::MAX_RECTS];
   logic [rmc_pkg::MAX_RECTS-1:0] written_ff;
   rmc_pkg::rect_type rd_data_ff;
   logic              rd_written_ff;
   rmc_pkg::rect_type rd_entry;
   rmc_pkg::idx_type  rd_addr;

   logic              wr_en;
   rmc_pkg::idx_type  wr_addr;
   rmc_pkg::rect_type wr_data;

   rmc_pkg::item_type   item_ff;
   rmc_pkg::idx_type    scan_ff;
   rmc_pkg::rect_type   cand_ff;
   rmc_pkg::coord_type  orig_x_ff, orig_y_ff;
   rmc_pkg::status_type status_ff;

   rmc_pkg::idx_type  last_idx;
   rmc_pkg::wide_type sum_x, sum_y;
   logic              in_range;
   logic              touch, hit, scan_end, out_free;

   rmc_pkg::wide_type ax, ay, bx, by;

   logic              out_load;
   rmc_pkg::status_type out_status;
   rmc_pkg::coord_type out_x, out_y;

   logic                rsp_valid_ff, rsp_valid_in;
   rmc_pkg::status_type rsp_status_ff;
   rmc_pkg::idx_type    rsp_index_ff;
   rmc_pkg::coord_type  rsp_x_ff, rsp_y_ff;

   assign last_idx = rmc_pkg::idx_type'(rmc_pkg::used_count(rect_count) - 1'b1);
   assign rd_entry = rd_written_ff ? rd_data_ff : rmc_pkg::RECT_RESET;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Candidate position; it is in range when the top three bits agree.
   assign sum_x    = rmc_pkg::wide_type'(rd_entry.x) + rmc_pkg::wide_type'(item_ff.delta_x);
   assign sum_y    = rmc_pkg::wide_type'(rd_entry.y) + rmc_pkg::wide_type'(item_ff.delta_y);
   assign in_range = (sum_x[17:15] == {3{sum_x[15]}}) && (sum_y[17:15] == {3{sum_y[15]}});

   // Closed-interval overlap test against the entry read for this scan step.
   assign ax    = rmc_pkg::wide_type'(cand_ff.x);
   assign ay    = rmc_pkg::wide_type'(cand_ff.y);
   assign bx    = rmc_pkg::wide_type'(rd_entry.x);
   assign by    = rmc_pkg::wide_type'(rd_entry.y);
   assign touch = (ax <= bx + rmc_pkg::wide_type'(rd_entry.w)) &&
                  (bx <= ax + rmc_pkg::wide_type'(cand_ff.w)) &&
                  (ay <= by + rmc_pkg::wide_type'(rd_entry.h)) &&
                  (by <= ay + rmc_pkg::wide_type'(cand_ff.h));
   assign hit      = touch && (scan_ff != item_ff.index);
   assign scan_end = hit || (scan_ff == last_idx);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmc_pkg::ST_IDLE: begin
            if (q_valid && out_free && q_item.kind == rmc_pkg::KIND_MOVE) begin
               state_in = rmc_pkg::ST_CAND;
            end
         end
         rmc_pkg::ST_CAND: begin
            state_in = in_range ? rmc_pkg::ST_SCAN : rmc_pkg::ST_DONE;
         end
         rmc_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = rmc_pkg::ST_DONE;
            end
         end
         rmc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rmc_pkg::ST_IDLE;
            end
         end
         default: state_in = rmc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      rd_addr    = item_ff.index;
      wr_en      = 1'b0;
      wr_addr    = item_ff.index;
      wr_data    = cand_ff;
      out_load   = 1'b0;
      out_status = status_ff;
      out_x      = orig_x_ff;
      out_y      = orig_y_ff;
      case (state_ff)
         rmc_pkg::ST_IDLE: begin
            rd_addr = q_item.index;
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  rmc_pkg::KIND_LOAD: begin
                     wr_en      = 1'b1;
                     wr_addr    = q_item.index;
                     wr_data    = q_item.rect;
                     out_load   = 1'b1;
                     out_status = rmc_pkg::STATUS_LOADED;
                     out_x      = q_item.rect.x;
                     out_y      = q_item.rect.y;
                  end
                  rmc_pkg::KIND_MOVE: begin
                     out_load = 1'b0;
                  end
                  default: begin
                     out_load   = 1'b1;
                     out_status = rmc_pkg::STATUS_BAD_INDEX;
                     out_x      = '0;
                     out_y      = '0;
                  end
               endcase
            end
         end
         rmc_pkg::ST_CAND: begin
            rd_addr = '0;
         end
         rmc_pkg::ST_SCAN: begin
            rd_addr = rmc_pkg::idx_type'(scan_ff + 1'b1);
         end
         rmc_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               if (status_ff == rmc_pkg::STATUS_MOVED) begin
                  wr_en = 1'b1;
                  out_x = cand_ff.x;
                  out_y = cand_ff.y;
               end
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rmc_pkg::ST_IDLE;
         written_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff    <= mem_ff[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      case (state_ff)
         rmc_pkg::ST_CAND: begin
            cand_ff.x <= rmc_pkg::coord_type'(sum_x);
            cand_ff.y <= rmc_pkg::coord_type'(sum_y);
            cand_ff.w <= rd_entry.w;
            cand_ff.h <= rd_entry.h;
            orig_x_ff <= rd_entry.x;
            orig_y_ff <= rd_entry.y;
            scan_ff   <= '0;
            status_ff <= in_range ? rmc_pkg::STATUS_MOVED : rmc_pkg::STATUS_RANGE;
         end
         rmc_pkg::ST_SCAN: begin
            scan_ff <= rmc_pkg::idx_type'(scan_ff + 1'b1);
            if (hit) begin
               status_ff <= rmc_pkg::STATUS_BLOCKED;
            end
         end
         default: scan_ff <= scan_ff;
      endcase
   end

   // Output register: holds a result while the receiver stalls.
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_index_ff  <= (state_ff == rmc_pkg::ST_IDLE) ? q_item.index : item_ff.index;
         rsp_x_ff      <= out_x;
         rsp_y_ff      <= out_y;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = 4'(rsp_index_ff);
   assign rsp_new_x       = rsp_x_ff;
   assign rsp_new_y       = rsp_y_ff;

endmodule

`default_nettype wire

// ===== design/rect_move_with_collision_core.sv =====
// Rectangle table with collision-checked moves.
// Input channel (req_*): one transfer is one item, either a load of a table
// entry (op 0) or a move of an entry by a signed distance in one direction
// (op 1). Result channel (rsp_*): exactly one transfer per item, in order,
// carrying a status code, the entry index and the entry position afterward.
// Both channels transfer when valid is high and stall is low.
// Configuration (csr_*): csr_wr_en writes csr_wr_data into the count of
// entries in use; write it only while no item is in flight.
// Path: a load or a bad index passes through the queue slot and then the
// output register. A move walks the entries in use through the table's single
// read port, one entry per cycle, after a candidate step, and stops early on a
// collision; a move out of coordinate range skips the walk. While the receiver
// does not stall, the back end takes a load or a bad index every cycle; it
// takes no new item while a move is under way.
// A two-entry queue sits between the input side and the execution side, so up
// to two items are taken while a result waits. When the receiver stalls, the
// result is held in the output register, the back end takes no new item and
// keeps any finished move waiting, and the input stalls once the queue fills.
// Reset returns every entry to a unit square at the origin, sets the count to
// 16 and empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module rect_move_with_collision_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [4:0]        csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [3:0]        req_index,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [14:0]       req_width,
   input  wire logic [14:0]       req_height,
   input  wire logic [2:0]        req_direction,
   input  wire logic signed [15:0] req_distance,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [3:0]             rsp_entry_index,
   output logic signed [15:0]     rsp_new_x,
   output logic signed [15:0]     rsp_new_y
);

   // Count of entries in use, as written over the configuration port.
   rmc_pkg::count_type rect_count_ff, rect_count_in;

   logic              push, queue_full, q_valid, q_pop;
   rmc_pkg::item_type push_item, q_item;

   assign rect_count_in = csr_wr_en ? rmc_pkg::count_type'(csr_wr_data) : rect_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_count_ff <= rmc_pkg::count_type'(16);
      end else begin
         rect_count_ff <= rect_count_in;
      end
   end

   // Front end: takes input transfers and sorts them into load, move or bad index.
   rmc_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_width     (req_width),
      .req_height    (req_height),
      .req_direction (req_direction),
      .req_distance  (req_distance),
      .rect_count    (rect_count_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   // Queue that decouples the two halves.
   rmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   // Back end: owns the table, runs the collision scan and the result register.
   rmc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rect_count      (rect_count_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_new_x       (rsp_new_x),
      .rsp_new_y       (rsp_new_y)
   );

endmodule

`default_nettype wire
